// File: hw/rtl/nfc_response_frame_checker_core_defines.svh
// assertion macros for the nfc response frame checker
// used by the top level only; expects clk and rst_n in scope
`ifndef NFC_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH
`define NFC_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NFCRFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define NFCRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/nfcrfc_pkg.sv
// shared types and constants of the nfc response frame checker
// no dependencies
package nfcrfc_pkg;

  localparam int READ_BYTES = 64;
  localparam int POS_W      = $clog2(READ_BYTES) + 1;
  localparam int CMP_W      = 10;

  // register indexes
  localparam logic [1:0] CFG_EXPECTED_COMMAND = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT       = 2'd1;
  localparam logic [1:0] CFG_REPLY_DIRECTION  = 2'd2;

  localparam logic [7:0]  RST_EXPECTED_COMMAND = 8'd0;
  localparam logic [15:0] RST_POLL_LIMIT       = 16'd100;
  localparam logic [7:0]  RST_REPLY_DIRECTION  = 8'd213;

  // result kinds and status codes
  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  // byte positions inside a read
  localparam int POS_PRE0  = 1;
  localparam int POS_PRE1  = 2;
  localparam int POS_PRE2  = 3;
  localparam int POS_LEN   = 4;
  localparam int POS_LCS   = 5;
  localparam int POS_DIR   = 6;
  localparam int POS_CMD   = 7;
  localparam int POS_DATA0 = 8;
  localparam int LEN_MIN   = 2;
  localparam int TAIL_OFS  = 6;

  localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
  localparam logic [7:0] PREAMBLE_END  = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'b01,
    PH_PARSE = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_read;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [5:0] data_index;
    logic [1:0] status_code;
    logic [7:0] frame_length;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  expected_command;
    logic [15:0] poll_limit;
    logic [7:0]  reply_direction_byte;
  } cfg_t;

endpackage

// File: hw/rtl/nfcrfc_parse.sv
// frame parser: parse state registers and the per-byte check logic
// depends on nfcrfc_pkg
module nfcrfc_parse import nfcrfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_word_t res
);

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [15:0]       poll_r, poll_nxt;
  logic [16:0]       poll_inc;
  logic [CMP_W-1:0]  last_pos;
  logic [CMP_W-1:0]  len_end;
  logic [7:0]        b;
  logic [7:0]        cmd_reply;
  logic [POS_W-1:0]  data_off;

  assign b         = word.rx_byte;
  assign poll_inc  = {1'b0, poll_r} + 17'd1;
  assign last_pos  = CMP_W'(len_r) + CMP_W'(TAIL_OFS);
  assign len_end   = CMP_W'(b) + CMP_W'(TAIL_OFS);
  assign cmd_reply = cfg.expected_command + 8'd1;
  assign data_off  = pos_r - POS_W'(POS_DATA0);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    poll_nxt  = poll_r;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = KIND_STATUS;

    if (word.first_of_read) begin
      phase_nxt = PH_IDLE;
      if (!b[0]) begin
        // not ready: one more poll
        if (poll_inc > {1'b0, cfg.poll_limit}) begin
          poll_nxt        = '0;
          res_valid       = 1'b1;
          res.status_code = ST_TIMEOUT;
        end else begin
          poll_nxt = poll_inc[15:0];
        end
      end else begin
        phase_nxt = PH_PARSE;
        pos_nxt   = POS_W'(1);
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_PARSE: begin
          pos_nxt = pos_r + POS_W'(1);
          case (pos_r) inside
            POS_W'(POS_PRE0), POS_W'(POS_PRE1): begin
              res_valid = (b != PREAMBLE_ZERO);
            end
            POS_W'(POS_PRE2): begin
              res_valid = (b != PREAMBLE_END);
            end
            POS_W'(POS_LEN): begin
              len_nxt   = b;
              res_valid = (b < 8'(LEN_MIN)) || (len_end >= CMP_W'(READ_BYTES));
            end
            POS_W'(POS_LCS): begin
              res_valid = ((len_r + b) != 8'd0);
            end
            POS_W'(POS_DIR): begin
              res_valid = (b != cfg.reply_direction_byte);
              sum_nxt   = b;
            end
            POS_W'(POS_CMD): begin
              res_valid = (b != cmd_reply);
              sum_nxt   = sum_r + b;
            end
            default: begin
              if (CMP_W'(pos_r) < last_pos) begin
                // payload byte
                sum_nxt        = sum_r + b;
                res_valid      = 1'b1;
                res.kind       = KIND_DATA;
                res.data_byte  = b;
                res.data_index = data_off[5:0];
              end else begin
                // data checksum closes the frame
                res_valid = 1'b1;
                if ((sum_r + b) == 8'd0) begin
                  res.status_code  = ST_OK;
                  res.frame_length = len_r;
                end else begin
                  res.status_code = ST_INVALID;
                end
              end
            end
          endcase
          // any failed check ends the frame as invalid
          if (res_valid && res.kind == KIND_STATUS && pos_r < POS_W'(POS_DATA0)) begin
            res.status_code = ST_INVALID;
          end
          if (res_valid && res.kind == KIND_STATUS) begin
            phase_nxt = PH_IDLE;
            poll_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      sum_r   <= '0;
      len_r   <= '0;
      poll_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      poll_r  <= poll_nxt;
    end
  end

endmodule

// File: hw/rtl/nfc_response_frame_checker_core.sv
// top level of the nfc response frame checker: config registers, parser, result register
// depends on nfcrfc_pkg, nfcrfc_parse and nfc_response_frame_checker_core_defines.svh
//
// channel  | signals                         | direction
// ---------+---------------------------------+----------
// in       | in_valid, in_ready, in_data     | in
// out      | out_valid, out_ready, out_data  | out
// cfg      | cfg_we, cfg_index, cfg_wdata    | in
//
// one word a cycle while in_ready is high: each byte is checked in the cycle it is accepted,
// result lands in the output register at the next edge
// the output register alone sets the rate; in_ready drops only while a result waits
// and out_ready is low
// synchronous active-low reset clears parse state, poll count and config to defaults
`include "nfc_response_frame_checker_core_defines.svh"
module nfc_response_frame_checker_core import nfcrfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      step;
  logic      res_valid;
  out_word_t res;
  logic      out_valid_r;
  out_word_t out_data_r;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_command     <= RST_EXPECTED_COMMAND;
      cfg_r.poll_limit           <= RST_POLL_LIMIT;
      cfg_r.reply_direction_byte <= RST_REPLY_DIRECTION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_COMMAND: cfg_r.expected_command     <= cfg_wdata[7:0];
        CFG_POLL_LIMIT:       cfg_r.poll_limit           <= cfg_wdata;
        CFG_REPLY_DIRECTION:  cfg_r.reply_direction_byte <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // take a new word whenever the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  nfcrfc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= step && res_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `NFCRFC_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ready, "input stalled with empty result register")
  `NFCRFC_ASSERT_NOW(a_data_clean, out_valid_r && out_data_r.kind == KIND_DATA, out_data_r.status_code == ST_OK && out_data_r.frame_length == 8'd0, "data word carries status fields")
  `NFCRFC_ASSERT_NOW(a_ok_length, out_valid_r && out_data_r.kind == KIND_STATUS && out_data_r.status_code == ST_OK, out_data_r.frame_length >= 8'(LEN_MIN), "ok status with short length")
  `NFCRFC_ASSERT_NOW(a_error_length, out_valid_r && out_data_r.kind == KIND_STATUS && out_data_r.status_code != ST_OK, out_data_r.frame_length == 8'd0, "error status carries a length")
  `NFCRFC_ASSERT_NEXT(a_no_result_no_valid, in_ready && !(step && res_valid), !out_valid_r, "result appeared without a cause")

endmodule

// File: test/nfc_response_frame_checker_core_test.sv
// self-checking testbench for nfc_response_frame_checker_core
// depends on nfcrfc_pkg and the core; a byte-level parser model predicts every result word
`timescale 1ns / 1ps
module nfc_response_frame_checker_core_test;
  import nfcrfc_pkg::*;

  typedef enum int {
    FLAW_NONE,
    FLAW_CORRUPT,
    FLAW_CUT,
    FLAW_BAD_SUM
  } flaw_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_EXPECTED_COMMAND;
  logic [15:0] cfg_wdata = '0;

  nfc_response_frame_checker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bytes waiting to be driven, result words the parser model says are due
  in_word_t  bus_bytes[$];
  out_word_t frame_results[$];

  // parser model state and its copy of the registers
  cfg_t             regs = '{RST_EXPECTED_COMMAND, RST_POLL_LIMIT, RST_REPLY_DIRECTION};
  logic [POS_W-1:0] rd_pos   = '0;
  logic [7:0]       rd_sum   = '0;
  logic [7:0]       rd_len   = '0;
  logic [15:0]      poll_cnt = '0;
  phase_t           rd_phase = PH_IDLE;

  int errors = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic out_word_t make_result(input logic kind, input logic [7:0] data,
                                            input logic [5:0] idx, input logic [1:0] status,
                                            input logic [7:0] flen);
    out_word_t r;
    r.kind         = kind;
    r.data_byte    = data;
    r.data_index   = idx;
    r.status_code  = status;
    r.frame_length = flen;
    return r;
  endfunction

  // any status word ends the operation and clears the poll count
  function automatic void close_frame(input logic [1:0] status, input logic [7:0] flen);
    rd_phase = PH_IDLE;
    poll_cnt = '0;
    frame_results.push_back(make_result(KIND_STATUS, 8'd0, 6'd0, status, flen));
  endfunction

  // advance the parser model by one accepted byte
  function automatic void parse_byte(input in_word_t w);
    logic [7:0]  b;
    logic [7:0]  s8;
    logic [16:0] next_polls;
    logic [5:0]  idx6;
    int          p;
    b = w.rx_byte;
    if (w.first_of_read) begin
      // a status byte always restarts, abandoning any frame in progress
      rd_phase = PH_IDLE;
      if (!b[0]) begin
        next_polls = {1'b0, poll_cnt} + 17'd1;
        if (next_polls > {1'b0, regs.poll_limit}) close_frame(ST_TIMEOUT, 8'd0);
        else poll_cnt = next_polls[15:0];
      end else begin
        rd_phase = PH_PARSE;
        rd_pos   = POS_W'(1);
      end
      return;
    end
    if (rd_phase != PH_PARSE) return;
    p      = int'(rd_pos);
    rd_pos = rd_pos + POS_W'(1);
    case (p)
      POS_PRE0, POS_PRE1: begin
        if (b != PREAMBLE_ZERO) close_frame(ST_INVALID, 8'd0);
      end
      POS_PRE2: begin
        if (b != PREAMBLE_END) close_frame(ST_INVALID, 8'd0);
      end
      POS_LEN: begin
        rd_len = b;
        // too short, or data checksum would fall outside the read
        if (b < LEN_MIN || b + TAIL_OFS >= READ_BYTES) close_frame(ST_INVALID, 8'd0);
      end
      POS_LCS: begin
        s8 = rd_len + b;
        if (s8 != 8'd0) close_frame(ST_INVALID, 8'd0);
      end
      POS_DIR: begin
        if (b != regs.reply_direction_byte) close_frame(ST_INVALID, 8'd0);
        else rd_sum = b;
      end
      POS_CMD: begin
        s8 = regs.expected_command + 8'd1;
        if (b != s8) close_frame(ST_INVALID, 8'd0);
        else rd_sum = rd_sum + b;
      end
      default: begin
        if (p < rd_len + TAIL_OFS) begin
          rd_sum = rd_sum + b;
          idx6   = 6'(p - POS_DATA0);
          frame_results.push_back(make_result(KIND_DATA, b, idx6, ST_OK, 8'd0));
        end else begin
          // data checksum; payload already passed on stays passed on
          s8 = rd_sum + b;
          if (s8 == 8'd0) close_frame(ST_OK, rd_len);
          else close_frame(ST_INVALID, 8'd0);
        end
      end
    endcase
  endfunction

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (frame_results.size() == 0) begin
      report($sformatf("result word with none due: kind %0d data %0h idx %0d st %0d len %0d",
                       got.kind, got.data_byte, got.data_index, got.status_code,
                       got.frame_length));
      return;
    end
    want = frame_results.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind got %0d want %0d", got.kind, want.kind));
    if (got.data_byte !== want.data_byte)
      report($sformatf("data_byte got %0h want %0h", got.data_byte, want.data_byte));
    if (got.data_index !== want.data_index)
      report($sformatf("data_index got %0d want %0d", got.data_index, want.data_index));
    if (got.status_code !== want.status_code)
      report($sformatf("status_code got %0d want %0d", got.status_code, want.status_code));
    if (got.frame_length !== want.frame_length)
      report($sformatf("frame_length got %0d want %0d", got.frame_length, want.frame_length));
  endtask

  // driver: predicts each accepted word, then offers the next one or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bus_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          in_data  <= bus_bytes.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor: checks accepted result words, stalls in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_data);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic first);
    in_word_t w;
    w.rx_byte       = b;
    w.first_of_read = first;
    bus_bytes.push_back(w);
  endfunction

  // one ready read carrying a reply frame built from the current registers
  // keep limits the frame bytes sent after the status byte, tail adds noise after it
  function automatic void queue_frame(input int len, input flaw_t flaw, input int keep,
                                      input int tail);
    logic [7:0] fb[$];
    logic [7:0] len8;
    logic [7:0] cs;
    logic [7:0] d;
    int         at;
    len8 = len[7:0];
    fb.push_back(PREAMBLE_ZERO);
    fb.push_back(PREAMBLE_ZERO);
    fb.push_back(PREAMBLE_END);
    fb.push_back(len8);
    fb.push_back(8'd0 - len8);
    fb.push_back(regs.reply_direction_byte);
    fb.push_back(regs.expected_command + 8'd1);
    cs = regs.reply_direction_byte + regs.expected_command + 8'd1;
    for (int i = 0; i < len - 2; i++) begin
      d = 8'($urandom_range(0, 255));
      fb.push_back(d);
      cs = cs + d;
    end
    fb.push_back(8'd0 - cs);
    case (flaw)
      FLAW_CORRUPT: begin
        at = $urandom_range(0, fb.size() - 1);
        fb[at] = fb[at] ^ 8'($urandom_range(1, 255));
      end
      FLAW_BAD_SUM: begin
        fb[fb.size() - 1] = fb[fb.size() - 1] ^ 8'($urandom_range(1, 255));
      end
      FLAW_CUT: begin
        // next status byte lands in the middle of the frame
        keep = $urandom_range(0, fb.size() - 1);
      end
      default: begin
      end
    endcase
    while (fb.size() > keep) fb.delete(fb.size() - 1);
    d    = 8'($urandom_range(0, 255));
    d[0] = 1'b1;
    push_byte(d, 1'b1);
    foreach (fb[i]) push_byte(fb[i], 1'b0);
    for (int i = 0; i < tail; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // frames with random payload in most picks, half of them flawed, the rest polls and noise
  task automatic fill_random(input int target);
    int         start;
    int         pick;
    int         sel;
    int         len;
    int         f;
    flaw_t      flaw;
    logic [7:0] sb;
    start = bus_bytes.size();
    while (bus_bytes.size() - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(58, 255);
        else if (sel < 3) len = $urandom_range(2, 57);
        else len = $urandom_range(2, 8);
        f    = $urandom_range(0, 19);
        flaw = (f < 10) ? FLAW_NONE : (f < 14) ? FLAW_CORRUPT : (f < 17) ? FLAW_CUT
                                                                         : FLAW_BAD_SUM;
        queue_frame(len, flaw, 255, $urandom_range(0, 2));
      end else if (pick < 80) begin
        // not-ready read: status byte with bit 0 clear, rest of read ignored
        sb    = 8'($urandom_range(0, 255));
        sb[0] = 1'b0;
        push_byte(sb, 1'b1);
        for (int i = $urandom_range(0, 3); i > 0; i--)
          push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 90) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // block is idle once nothing is queued or due
  task automatic wait_drained();
    while (bus_bytes.size() != 0 || in_valid || frame_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_EXPECTED_COMMAND: regs.expected_command     = val[7:0];
      CFG_POLL_LIMIT:       regs.poll_limit           = val;
      CFG_REPLY_DIRECTION:  regs.reply_direction_byte = val[7:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0]  cmd;
    logic [7:0]  dir;
    logic [7:0]  junk;
    logic [15:0] lim;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle noise, a poll, a good frame, short and too-long lengths
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFE, 1'b1);
    queue_frame(3, FLAW_NONE, 255, 0);
    queue_frame(1, FLAW_NONE, 4, 0);
    queue_frame(58, FLAW_NONE, 4, 0);
    fill_random(60);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      if (ph == 0) begin
        cmd = 8'hFF;
        lim = 16'd0;
        dir = 8'h00;
      end else if (ph == 1) begin
        cmd = 8'h00;
        lim = 16'hFFFF;
        dir = 8'hFF;
      end else begin
        cmd = 8'($urandom_range(0, 255));
        lim = 16'($urandom_range(0, 5));
        dir = $urandom_range(0, 1) ? RST_REPLY_DIRECTION : 8'($urandom_range(0, 255));
      end
      // upper data bits of the 8-bit registers are don't-care
      junk = 8'($urandom_range(0, 255));
      cfg_write(CFG_EXPECTED_COMMAND, {junk, cmd});
      cfg_write(CFG_POLL_LIMIT, lim);
      cfg_write(CFG_REPLY_DIRECTION, {~junk, dir});
      if (ph == 7) steady = 1'b1;
      fill_random(100);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("nfc_response_frame_checker_core_test: PASS");
    end else begin
      $display("nfc_response_frame_checker_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("nfc_response_frame_checker_core_test: FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/nfcrfc_pkg.sv
hw/rtl/nfcrfc_parse.sv
hw/rtl/nfc_response_frame_checker_core.sv
test/nfc_response_frame_checker_core_test.sv
